/* hw/rtl/rsh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_pkg
// shared constants, types and the hue blend function of the shading pipeline
// ----------------------------------------------------------------------------
package rsh_pkg;

   localparam int FRAC = 20;
   localparam int VW = FRAC + 1;
   localparam int DIV_STEPS = VW;
   localparam int HW = FRAC + 4;

   localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC;
   localparam logic [VW-1:0] HALF_V = VW'(1) << (FRAC - 1);

   localparam logic signed [HW-1:0] ONE_H = HW'(1) <<< FRAC;
   localparam logic signed [HW-1:0] TWO_H = HW'(2) <<< FRAC;
   localparam logic signed [HW-1:0] THREE_H = HW'(3) <<< FRAC;
   localparam logic signed [HW-1:0] FOUR_H = HW'(4) <<< FRAC;
   localparam logic signed [HW-1:0] SIX_H = HW'(6) <<< FRAC;

   localparam logic [15:0] K_ONE = 16'd16384;
   localparam logic [15:0] CH_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   typedef struct packed {
      logic        hsl;
      logic [15:0] byp_red;
      logic [15:0] byp_green;
      logic [15:0] byp_blue;
      logic [19:0] light;
      sector_type  sector;
      logic        hue_neg;
      logic        grey;
      logic [15:0] factor;
   } tag_type;

   // one channel of the hsl to rgb conversion
   function automatic logic [VW-1:0] hue_channel(input logic signed [HW-1:0] h_raw,
                                                 input logic [VW-1:0] m1,
                                                 input logic [VW-1:0] m2);
      logic signed [HW-1:0] h;
      logic [VW-1:0]        span;
      logic [VW-1:0]        t;
      logic [2*VW-1:0]      prod;
      logic [VW-1:0]        blended;
      logic [VW-1:0]        res;
      h = h_raw;
      if (h < 0) begin
         h = h + SIX_H;
      end
      if (h >= SIX_H) begin
         h = h - SIX_H;
      end
      span = m2 - m1;
      priority if (h < ONE_H) begin
         t = h[VW-1:0];
      end else if (h >= THREE_H && h < FOUR_H) begin
         t = VW'(FOUR_H - h);
      end else begin
         t = '0;
      end
      prod = {{VW{1'b0}}, span} * {{VW{1'b0}}, t};
      blended = m1 + prod[FRAC +: VW];
      priority if (h < ONE_H) begin
         res = blended;
      end else if (h < THREE_H) begin
         res = m2;
      end else if (h < FOUR_H) begin
         res = blended;
      end else begin
         res = m1;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/rsh_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsh channel interfaces
// valid/ready channels for colour requests and shaded responses
// ----------------------------------------------------------------------------
interface rsh_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] in_red;
   logic [15:0] in_green;
   logic [15:0] in_blue;
   logic [15:0] shade_factor;
   modport source (output valid, output in_red, output in_green, output in_blue,
                   output shade_factor, input ready);
   modport sink (input valid, input in_red, input in_green, input in_blue,
                 input shade_factor, output ready);
endinterface

interface rsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   modport source (output valid, output out_red, output out_green, output out_blue,
                   input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 output ready);
endinterface
`default_nettype wire

/* hw/rtl/rsh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_front
// min/max, lightness, divider operands and the simple/bypass result
// ----------------------------------------------------------------------------
module rsh_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            mode,
   input  wire logic            in_valid,
   input  wire logic [15:0]     in_red,
   input  wire logic [15:0]     in_green,
   input  wire logic [15:0]     in_blue,
   input  wire logic [15:0]     factor,
   output logic                 out_valid,
   output rsh_pkg::tag_type     out_tag,
   output logic [19:0]          s_num,
   output logic [20:0]          s_den,
   output logic [19:0]          h_num,
   output logic [20:0]          h_den
);

   logic [19:0] r, g, b, mx, mn, delta, ha, hb;
   logic [20:0] sum;
   logic [21:0] inv_sum;
   logic [18:0] t_red, t_green, t_blue;
   logic [15:0] simp_red, simp_green, simp_blue;
   rsh_pkg::tag_type tag_in, tag_ff;
   logic        valid_ff;
   logic [19:0] s_num_ff, h_num_ff;
   logic [20:0] s_den_ff, h_den_ff, s_den_in;

   function automatic logic [15:0] simple_ch(input logic [18:0] t);
      logic [15:0] v;
      priority if (t < 19'd65536) begin
         v = '0;
      end else if (t >= 19'd131072) begin
         v = rsh_pkg::CH_MAX;
      end else begin
         v = t[15:0];
      end
      return v;
   endfunction

   always_comb begin
      r = {in_red, 4'b0};
      g = {in_green, 4'b0};
      b = {in_blue, 4'b0};
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = {1'b0, mx} + {1'b0, mn};
      delta = mx - mn;
      inv_sum = 22'h20_0000 - {1'b0, sum};
      s_den_in = (sum[20:1] <= rsh_pkg::HALF_V[19:0]) ? sum : inv_sum[20:0];

      tag_in.light = sum[20:1];
      tag_in.grey = (mx == mn);
      tag_in.factor = factor;
      priority if (r == mx) begin
         tag_in.sector = rsh_pkg::SEC_RED;
         ha = g;
         hb = b;
      end else if (g == mx) begin
         tag_in.sector = rsh_pkg::SEC_GREEN;
         ha = b;
         hb = r;
      end else begin
         tag_in.sector = rsh_pkg::SEC_BLUE;
         ha = r;
         hb = g;
      end
      tag_in.hue_neg = (ha < hb);

      t_red = {3'b0, in_red} + {1'b0, factor, 2'b0};
      t_green = {3'b0, in_green} + {1'b0, factor, 2'b0};
      t_blue = {3'b0, in_blue} + {1'b0, factor, 2'b0};
      simp_red = simple_ch(t_red);
      simp_green = simple_ch(t_green);
      simp_blue = simple_ch(t_blue);

      tag_in.hsl = 1'b0;
      priority if (factor == rsh_pkg::K_ONE) begin
         tag_in.byp_red = in_red;
         tag_in.byp_green = in_green;
         tag_in.byp_blue = in_blue;
      end else if (!mode) begin
         tag_in.byp_red = simp_red;
         tag_in.byp_green = simp_green;
         tag_in.byp_blue = simp_blue;
      end else begin
         tag_in.hsl = 1'b1;
         tag_in.byp_red = in_red;
         tag_in.byp_green = in_green;
         tag_in.byp_blue = in_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff <= tag_in;
         s_num_ff <= delta;
         s_den_ff <= s_den_in;
         h_num_ff <= tag_in.hue_neg ? (hb - ha) : (ha - hb);
         h_den_ff <= {1'b0, delta};
      end
   end

   assign out_valid = valid_ff;
   assign out_tag = tag_ff;
   assign s_num = s_num_ff;
   assign s_den = s_den_ff;
   assign h_num = h_num_ff;
   assign h_den = h_den_ff;

endmodule
`default_nettype wire

/* hw/rtl/rsh_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_divider
// two pipelined restoring dividers, one quotient bit per stage
// ----------------------------------------------------------------------------
module rsh_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire rsh_pkg::tag_type  in_tag,
   input  wire logic [19:0]       s_num,
   input  wire logic [20:0]       s_den,
   input  wire logic [19:0]       h_num,
   input  wire logic [20:0]       h_den,
   output logic                   out_valid,
   output rsh_pkg::tag_type       out_tag,
   output logic [rsh_pkg::VW-1:0] s_quo,
   output logic [rsh_pkg::VW-1:0] h_quo
);

   localparam int N = rsh_pkg::DIV_STEPS;
   localparam int VW = rsh_pkg::VW;

   logic             valid_ff [N];
   rsh_pkg::tag_type tag_ff [N];
   logic [21:0]      srem_ff [N];
   logic [21:0]      hrem_ff [N];
   logic [20:0]      sden_ff [N];
   logic [20:0]      hden_ff [N];
   logic [VW-1:0]    sq_ff [N];
   logic [VW-1:0]    hq_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic             valid_src;
      rsh_pkg::tag_type tag_src;
      logic [21:0]      srem_src, hrem_src;
      logic [20:0]      sden_src, hden_src;
      logic [VW-1:0]    sq_src, hq_src;
      logic [21:0]      srem_in, hrem_in;
      logic [VW-1:0]    sq_in, hq_in;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign tag_src = in_tag;
         assign srem_src = {2'b0, s_num};
         assign hrem_src = {2'b0, h_num};
         assign sden_src = s_den;
         assign hden_src = h_den;
         assign sq_src = '0;
         assign hq_src = '0;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign tag_src = tag_ff[i-1];
         assign srem_src = {srem_ff[i-1][20:0], 1'b0};
         assign hrem_src = {hrem_ff[i-1][20:0], 1'b0};
         assign sden_src = sden_ff[i-1];
         assign hden_src = hden_ff[i-1];
         assign sq_src = sq_ff[i-1];
         assign hq_src = hq_ff[i-1];
      end

      always_comb begin
         if (srem_src >= {1'b0, sden_src}) begin
            srem_in = srem_src - {1'b0, sden_src};
            sq_in = {sq_src[VW-2:0], 1'b1};
         end else begin
            srem_in = srem_src;
            sq_in = {sq_src[VW-2:0], 1'b0};
         end
         if (hrem_src >= {1'b0, hden_src}) begin
            hrem_in = hrem_src - {1'b0, hden_src};
            hq_in = {hq_src[VW-2:0], 1'b1};
         end else begin
            hrem_in = hrem_src;
            hq_in = {hq_src[VW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[i] <= tag_src;
            srem_ff[i] <= srem_in;
            hrem_ff[i] <= hrem_in;
            sden_ff[i] <= sden_src;
            hden_ff[i] <= hden_src;
            sq_ff[i] <= sq_in;
            hq_ff[i] <= hq_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_tag = tag_ff[N-1];
   assign s_quo = sq_ff[N-1];
   assign h_quo = hq_ff[N-1];

endmodule
`default_nettype wire

/* hw/rtl/rsh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rsh_back
// hue, scaled lightness/saturation, m1/m2, channel blend and output register
// ----------------------------------------------------------------------------
module rsh_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire rsh_pkg::tag_type  in_tag,
   input  wire logic [rsh_pkg::VW-1:0] s_quo,
   input  wire logic [rsh_pkg::VW-1:0] h_quo,
   output logic                   out_valid,
   output logic [15:0]            out_red,
   output logic [15:0]            out_green,
   output logic [15:0]            out_blue
);

   localparam int VW = rsh_pkg::VW;
   localparam int HW = rsh_pkg::HW;
   localparam int FRAC = rsh_pkg::FRAC;

   // stage 1: hue and scaling
   logic signed [HW-1:0] base_h, qs_h, hsum_h;
   logic [VW-1:0]        s_eff, l1_in, s1_in;
   logic [35:0]          lk_prod;
   logic [36:0]          sk_prod;
   logic [HW-2:0]        h1_in;
   logic                 v1_ff;
   rsh_pkg::tag_type     t1_ff;
   logic [HW-2:0]        h1_ff;
   logic [VW-1:0]        l1_ff, s1_ff;

   always_comb begin
      unique case (in_tag.sector)
         rsh_pkg::SEC_RED:   base_h = '0;
         rsh_pkg::SEC_GREEN: base_h = rsh_pkg::TWO_H;
         rsh_pkg::SEC_BLUE:  base_h = rsh_pkg::FOUR_H;
         default:            base_h = '0;
      endcase
      qs_h = $signed({{(HW-VW){1'b0}}, h_quo});
      hsum_h = in_tag.hue_neg ? (base_h - qs_h) : (base_h + qs_h);
      if (hsum_h < 0) begin
         hsum_h = hsum_h + rsh_pkg::SIX_H;
      end
      h1_in = in_tag.grey ? '0 : hsum_h[HW-2:0];
      s_eff = in_tag.grey ? '0 : s_quo;
      lk_prod = {16'b0, in_tag.light} * {20'b0, in_tag.factor};
      sk_prod = {16'b0, s_eff} * {21'b0, in_tag.factor};
      l1_in = (lk_prod[35:14] > {1'b0, rsh_pkg::ONE_V}) ? rsh_pkg::ONE_V : lk_prod[34:14];
      s1_in = (sk_prod[36:14] > {2'b0, rsh_pkg::ONE_V}) ? rsh_pkg::ONE_V : sk_prod[34:14];
   end

   // stage 2: m2
   logic                 le_half;
   logic [VW-1:0]        mul_a;
   logic [VW:0]          mul_b;
   logic [2*VW:0]        m_prod;
   logic [VW-1:0]        m2_in;
   logic                 v2_ff;
   rsh_pkg::tag_type     t2_ff;
   logic [HW-2:0]        h2_ff;
   logic [VW-1:0]        l2_ff, m2_ff;

   always_comb begin
      le_half = (l1_ff <= rsh_pkg::HALF_V);
      mul_a = le_half ? l1_ff : s1_ff;
      mul_b = le_half ? ({1'b0, rsh_pkg::ONE_V} + {1'b0, s1_ff})
                      : ({1'b0, rsh_pkg::ONE_V} - {1'b0, l1_ff});
      m_prod = {{(VW+1){1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};
      m2_in = le_half ? m_prod[FRAC +: VW] : (l1_ff + m_prod[FRAC +: VW]);
   end

   // stage 3: channel blend
   logic [VW:0]          m1_wide;
   logic [VW-1:0]        m1;
   logic signed [HW-1:0] h2_s;
   logic                 v3_ff;
   rsh_pkg::tag_type     t3_ff;
   logic [VW-1:0]        xr_ff, xg_ff, xb_ff;

   always_comb begin
      m1_wide = {l2_ff, 1'b0} - {1'b0, m2_ff};
      m1 = m1_wide[VW-1:0];
      h2_s = $signed({1'b0, h2_ff});
   end

   // stage 4: rounding and output register
   function automatic logic [15:0] to_q16(input logic [VW-1:0] x);
      logic [VW-1:0] xc;
      logic [VW:0]   rs;
      xc = (x > rsh_pkg::ONE_V) ? rsh_pkg::ONE_V : x;
      rs = {1'b0, xc} + (VW+1)'(8);
      return rs[VW-1] ? rsh_pkg::CH_MAX : rs[19:4];
   endfunction

   logic        v4_ff;
   logic [15:0] or_ff, og_ff, ob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= in_tag;
         h1_ff <= h1_in;
         l1_ff <= l1_in;
         s1_ff <= s1_in;
         t2_ff <= t1_ff;
         h2_ff <= h1_ff;
         l2_ff <= l1_ff;
         m2_ff <= m2_in;
         t3_ff <= t2_ff;
         xr_ff <= rsh_pkg::hue_channel(h2_s + rsh_pkg::TWO_H, m1, m2_ff);
         xg_ff <= rsh_pkg::hue_channel(h2_s, m1, m2_ff);
         xb_ff <= rsh_pkg::hue_channel(h2_s - rsh_pkg::TWO_H, m1, m2_ff);
         or_ff <= t3_ff.hsl ? to_q16(xr_ff) : t3_ff.byp_red;
         og_ff <= t3_ff.hsl ? to_q16(xg_ff) : t3_ff.byp_green;
         ob_ff <= t3_ff.hsl ? to_q16(xb_ff) : t3_ff.byp_blue;
      end
   end

   assign out_valid = v4_ff;
   assign out_red = or_ff;
   assign out_green = og_ff;
   assign out_blue = ob_ff;

endmodule
`default_nettype wire

/* hw/rtl/rgb_shade_via_hsl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_shade_via_hsl
// shades an rgb colour by a factor k, simply or through hsl
// ----------------------------------------------------------------------------
// req carries one colour word (Q0.16 channels) and shade_factor (Q2.14);
// rsp returns the shaded colour word. csr_write_en/csr_write_data set the
// shading mode (0 simple, 1 hsl), which resets to 1; the user must write it
// only while the pipeline is empty, as the block does not enforce this.
// The pipeline has one front stage, 21 divider stages (one quotient
// bit per stage for saturation and hue), and four back stages ending in the
// output register. A new word is taken every cycle unless rsp stalls.
// The whole pipeline advances together: when rsp holds a word that is not
// taken, every stage and req.ready hold until rsp.ready returns, so no word
// is lost or repeated. Reset clears all valid bits; the pipeline is empty
// and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module rgb_shade_via_hsl (
   input  wire logic  clock,
   input  wire logic  reset,
   rsh_req_if.sink    req,
   rsh_rsp_if.source  rsp,
   input  wire logic  csr_write_en,
   input  wire logic  csr_write_data
);

   logic             mode_ff;
   logic             adv;
   logic             f_valid, d_valid;
   rsh_pkg::tag_type f_tag, d_tag;
   logic [19:0]      s_num, h_num;
   logic [20:0]      s_den, h_den;
   logic [rsh_pkg::VW-1:0] s_quo, h_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   rsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .mode      (mode_ff),
      .in_valid  (req.valid),
      .in_red    (req.in_red),
      .in_green  (req.in_green),
      .in_blue   (req.in_blue),
      .factor    (req.shade_factor),
      .out_valid (f_valid),
      .out_tag   (f_tag),
      .s_num     (s_num),
      .s_den     (s_den),
      .h_num     (h_num),
      .h_den     (h_den)
   );

   rsh_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_tag    (f_tag),
      .s_num     (s_num),
      .s_den     (s_den),
      .h_num     (h_num),
      .h_den     (h_den),
      .out_valid (d_valid),
      .out_tag   (d_tag),
      .s_quo     (s_quo),
      .h_quo     (h_quo)
   );

   rsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid),
      .in_tag    (d_tag),
      .s_quo     (s_quo),
      .h_quo     (h_quo),
      .out_valid (rsp.valid),
      .out_red   (rsp.out_red),
      .out_green (rsp.out_green),
      .out_blue  (rsp.out_blue)
   );

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid right after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input taken while output stalled");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (d_valid && d_tag.hsl && !d_tag.grey) |->
         (s_quo <= rsh_pkg::ONE_V && h_quo <= rsh_pkg::ONE_V))
      else $error("divider quotient above one");

endmodule
`default_nettype wire
